[rtl/tgd_pkg.sv]
// Shared types, constants and register indexes of the tilt gesture detector.
package tgd_pkg;

   localparam int TIME_BITS      = 48;
   localparam int ACCEL_BITS     = 16;
   localparam int LEVEL_BITS     = 15;
   localparam int BAND_BITS      = 12;
   localparam int COUNT_BITS     = 4;
   localparam int DEBOUNCE_BITS  = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int LIMIT_BITS     = 13;
   localparam int LIMIT_SQ_BITS  = 2 * LIMIT_BITS;
   localparam int MAG_SQ_BITS    = 2 * ACCEL_BITS;

   localparam int ONE_G = 4096;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DETECT_ENABLE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEUTRAL_LEVEL    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_LEVEL    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEADY_BAND      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONFIRM_COUNT    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TIME    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOWN_IS_POSITIVE = 3'd6;

   localparam int RST_NEUTRAL_LEVEL = 1638;
   localparam int RST_TRIGGER_LEVEL = 2867;
   localparam int RST_STEADY_BAND   = 2253;
   localparam int RST_CONFIRM_COUNT = 2;
   localparam int RST_DEBOUNCE_TIME = 700000;
   localparam int RST_LO            = ONE_G - RST_STEADY_BAND;
   localparam int RST_HI            = ONE_G + RST_STEADY_BAND;
   localparam int RST_LO_SQ         = RST_LO * RST_LO;
   localparam int RST_HI_SQ         = RST_HI * RST_HI;

   localparam logic [COUNT_BITS-1:0] HIT_MAX = '1;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;
   localparam logic [1:0] DIR_UP   = 2'd2;

   typedef struct packed {
      logic                     detect_enable;
      logic [LEVEL_BITS-1:0]    neutral_level;
      logic [LEVEL_BITS-1:0]    trigger_level;
      logic [COUNT_BITS-1:0]    confirm_count;
      logic [DEBOUNCE_BITS-1:0] debounce_time;
      logic                     down_is_positive;
      logic [LIMIT_SQ_BITS-1:0] lo_sq;
      logic [LIMIT_SQ_BITS-1:0] hi_sq;
   } cfg_type;

endpackage

[rtl/tgd_csr.sv]
// Configuration registers, with the squared steady band limits kept beside them.
module tgd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [tgd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tgd_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output tgd_pkg::cfg_type                     cfg
);
   import tgd_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   logic [LIMIT_BITS-1:0] lo_lim, hi_lim;

   // band limits from the incoming band value; lo never reaches zero
   assign lo_lim = LIMIT_BITS'(ONE_G) - {1'b0, csr_wdata[BAND_BITS-1:0]};
   assign hi_lim = LIMIT_BITS'(ONE_G) + {1'b0, csr_wdata[BAND_BITS-1:0]};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DETECT_ENABLE:    cfg_in.detect_enable    = csr_wdata[0];
            CSR_NEUTRAL_LEVEL:    cfg_in.neutral_level    = csr_wdata[LEVEL_BITS-1:0];
            CSR_TRIGGER_LEVEL:    cfg_in.trigger_level    = csr_wdata[LEVEL_BITS-1:0];
            CSR_STEADY_BAND: begin
               cfg_in.lo_sq = LIMIT_SQ_BITS'(lo_lim) * LIMIT_SQ_BITS'(lo_lim);
               cfg_in.hi_sq = LIMIT_SQ_BITS'(hi_lim) * LIMIT_SQ_BITS'(hi_lim);
            end
            CSR_CONFIRM_COUNT:    cfg_in.confirm_count    = csr_wdata[COUNT_BITS-1:0];
            CSR_DEBOUNCE_TIME:    cfg_in.debounce_time    = csr_wdata[DEBOUNCE_BITS-1:0];
            CSR_DOWN_IS_POSITIVE: cfg_in.down_is_positive = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_enable    <= 1'b1;
         cfg_ff.neutral_level    <= LEVEL_BITS'(RST_NEUTRAL_LEVEL);
         cfg_ff.trigger_level    <= LEVEL_BITS'(RST_TRIGGER_LEVEL);
         cfg_ff.confirm_count    <= COUNT_BITS'(RST_CONFIRM_COUNT);
         cfg_ff.debounce_time    <= DEBOUNCE_BITS'(RST_DEBOUNCE_TIME);
         cfg_ff.down_is_positive <= 1'b1;
         cfg_ff.lo_sq            <= LIMIT_SQ_BITS'(RST_LO_SQ);
         cfg_ff.hi_sq            <= LIMIT_SQ_BITS'(RST_HI_SQ);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/tgd_core.sv]
// Gesture decision for one registered request, with armed, hit count and last fire time.
module tgd_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     go,
   input  logic                                     func,
   input  logic signed [tgd_pkg::ACCEL_BITS-1:0]    accel_x,
   input  logic signed [tgd_pkg::ACCEL_BITS-1:0]    accel_y,
   input  logic signed [tgd_pkg::ACCEL_BITS-1:0]    accel_z,
   input  logic [tgd_pkg::TIME_BITS-1:0]            time_us,
   input  tgd_pkg::cfg_type                         cfg,
   output logic [1:0]                               direction
);
   import tgd_pkg::*;

   logic                   armed_ff, armed_in;
   logic [COUNT_BITS-1:0]  hit_ff, hit_in, hit_inc;
   logic [TIME_BITS-1:0]   last_ff, last_in, elapsed;
   logic [ACCEL_BITS-1:0]  ax, ay, an;
   logic [MAG_SQ_BITS-1:0] sq;
   logic                   steady, hit, elapsed_ok, positive;

   assign ax = accel_x[ACCEL_BITS-1] ? ACCEL_BITS'(-accel_x) : accel_x;
   assign ay = accel_y[ACCEL_BITS-1] ? ACCEL_BITS'(-accel_y) : accel_y;
   assign an = accel_z[ACCEL_BITS-1] ? ACCEL_BITS'(-accel_z) : accel_z;

   // total fits: three squares of at most 2^30
   assign sq = MAG_SQ_BITS'(ax) * MAG_SQ_BITS'(ax) +
               MAG_SQ_BITS'(ay) * MAG_SQ_BITS'(ay) +
               MAG_SQ_BITS'(an) * MAG_SQ_BITS'(an);
   assign steady = (sq > MAG_SQ_BITS'(cfg.lo_sq)) && (sq < MAG_SQ_BITS'(cfg.hi_sq));
   assign hit = steady && (an >= ACCEL_BITS'(cfg.trigger_level));
   assign hit_inc = (hit_ff != HIT_MAX) ? hit_ff + 1'b1 : hit_ff;

   assign elapsed = time_us - last_ff;
   assign elapsed_ok = (time_us >= last_ff) &&
                       (elapsed >= TIME_BITS'(cfg.debounce_time));
   assign positive = !accel_z[ACCEL_BITS-1] && (accel_z != '0);

   always_comb begin
      armed_in  = armed_ff;
      hit_in    = hit_ff;
      last_in   = last_ff;
      direction = DIR_NONE;
      if (func) begin
         armed_in = 1'b1;
         hit_in   = '0;
         last_in  = '0;
      end else if (cfg.detect_enable) begin
         if (!armed_ff) begin
            if (an < ACCEL_BITS'(cfg.neutral_level)) armed_in = 1'b1;
         end else if (!hit) begin
            hit_in = '0;
         end else if (hit_inc < cfg.confirm_count) begin
            hit_in = hit_inc;
         end else begin
            hit_in = '0;
            if (elapsed_ok) begin
               last_in  = time_us;
               armed_in = 1'b0;
               direction = (positive == cfg.down_is_positive) ? DIR_DOWN : DIR_UP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b1;
         hit_ff   <= '0;
         last_ff  <= '0;
      end else if (go) begin
         armed_ff <= armed_in;
         hit_ff   <= hit_in;
         last_ff  <= last_in;
      end
   end

   a_fire_disarms: assert property (@(posedge clock) disable iff (reset)
      go && (direction != DIR_NONE) |=> !armed_ff && (last_ff == $past(time_us)))
      else $error("fired gesture did not disarm");

   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      go && !func && !cfg.detect_enable |=> $stable(hit_ff) && $stable(armed_ff))
      else $error("state changed while detection disabled");

   a_rearm_clears: assert property (@(posedge clock) disable iff (reset)
      go && func |=> armed_ff && (hit_ff == '0) && (last_ff == '0))
      else $error("rearm did not clear state");

   a_disarmed_quiet: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (direction == DIR_NONE))
      else $error("report while disarmed");

endmodule

[rtl/tilt_gesture_detector.sv]
// Top level of the tilt gesture detector: request register, decision, response register.
//
// Requests carry one accelerometer sample (x, y, z at 4096 counts per g, and a
// microsecond timestamp) or a rearm command (req_func = 1). Each request gives
// exactly one response with rsp_direction: none, tilted down or tilted up.
// A request is taken at a clock edge with req_valid high and req_stall low;
// a response is taken with rsp_valid high and rsp_stall low.
// A request passes through the request register, then the decision logic writes
// the response register and updates the detector state in the same edge.
// Throughput is one request per cycle, set by the single decision stage, unless rsp_stall.
// When the receiver stalls, the response holds, the request register still
// fills once, and req_stall rises only when both registers are occupied.
// Synchronous reset empties both registers, arms the detector, clears the hit
// count and last fire time, and restores the configuration reset values.
// The user writes configuration through csr_we / csr_index / csr_wdata only while idle;
// the block does not check it; a steady band write also updates the squared band limits.
module tilt_gesture_detector (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_func,
   input  logic signed [tgd_pkg::ACCEL_BITS-1:0]    req_accel_x,
   input  logic signed [tgd_pkg::ACCEL_BITS-1:0]    req_accel_y,
   input  logic signed [tgd_pkg::ACCEL_BITS-1:0]    req_accel_z,
   input  logic [tgd_pkg::TIME_BITS-1:0]            req_time_us,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [1:0]                               rsp_direction,
   input  logic                                     csr_we,
   input  logic [tgd_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [tgd_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);
   import tgd_pkg::*;

   cfg_type                      cfg;
   logic                         s1_valid_ff, rsp_valid_ff;
   logic                         s1_func_ff;
   logic signed [ACCEL_BITS-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic [TIME_BITS-1:0]         s1_time_ff;
   logic [1:0]                   dir_in, rsp_dir_ff;
   logic                         advance, go, take;

   tgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // advance when the response register is free or being emptied
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign go        = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   tgd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .func      (s1_func_ff),
      .accel_x   (s1_x_ff),
      .accel_y   (s1_y_ff),
      .accel_z   (s1_z_ff),
      .time_us   (s1_time_ff),
      .cfg       (cfg),
      .direction (dir_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // hold a stalled request, otherwise load whatever is taken
         s1_valid_ff <= take || req_stall;
         if (advance) rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_func_ff <= req_func;
         s1_x_ff    <= req_accel_x;
         s1_y_ff    <= req_accel_y;
         s1_z_ff    <= req_accel_z;
         s1_time_ff <= req_time_us;
      end
      if (go) rsp_dir_ff <= dir_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_direction = rsp_dir_ff;

   a_stall_holds_request: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> s1_valid_ff)
      else $error("held request dropped");

   a_go_fills_response: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("decided request produced no response");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("request stalled with room downstream");

endmodule

[tb/tilt_gesture_detector_test.sv]
// Self-checking testbench for the tilt gesture detector: directed and random requests.
`timescale 1ns / 100ps

module tilt_gesture_detector_test;
   import tgd_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 50;

   typedef struct {
      logic                     enable;
      logic [LEVEL_BITS-1:0]    neutral;
      logic [LEVEL_BITS-1:0]    trigger;
      logic [BAND_BITS-1:0]     band;
      logic [COUNT_BITS-1:0]    confirm;
      logic [DEBOUNCE_BITS-1:0] debounce;
      logic                     down_pos;
   } tilt_settings_type;

   typedef struct {
      logic                         func;
      logic signed [ACCEL_BITS-1:0] x;
      logic signed [ACCEL_BITS-1:0] y;
      logic signed [ACCEL_BITS-1:0] z;
      logic [TIME_BITS-1:0]         t;
   } sample_type;

   localparam tilt_settings_type RESET_SETTINGS = '{1'b1, 15'(RST_NEUTRAL_LEVEL),
      15'(RST_TRIGGER_LEVEL), 12'(RST_STEADY_BAND), 4'(RST_CONFIRM_COUNT),
      24'(RST_DEBOUNCE_TIME), 1'b1};
   // everything steady and tilted enough fires at once
   localparam tilt_settings_type FIRE_SETTINGS = '{1'b1, 15'h7FFF, 15'd0, 12'hFFF, 4'd1,
      24'd0, 1'b0};
   // detection off, and limits that could never qualify anyway
   localparam tilt_settings_type QUIET_SETTINGS = '{1'b0, 15'd0, 15'h7FFF, 12'd0, 4'hF,
      24'hFFFFFF, 1'b1};

   class tilt_scoreboard;
      tilt_settings_type setting;
      logic              armed;
      logic [3:0]        hits;
      logic [47:0]       last_fire;
      logic [1:0]        expected_dirs[$];
      int                errors, requests, responses, downs, ups;

      function new();
         setting   = RESET_SETTINGS;
         armed     = 1'b1;
         hits      = '0;
         last_fire = '0;
      endfunction

      function void write_setting(logic [CSR_INDEX_BITS-1:0] index,
                                  logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_DETECT_ENABLE:    setting.enable   = value[0];
            CSR_NEUTRAL_LEVEL:    setting.neutral  = value[LEVEL_BITS-1:0];
            CSR_TRIGGER_LEVEL:    setting.trigger  = value[LEVEL_BITS-1:0];
            CSR_STEADY_BAND:      setting.band     = value[BAND_BITS-1:0];
            CSR_CONFIRM_COUNT:    setting.confirm  = value[COUNT_BITS-1:0];
            CSR_DEBOUNCE_TIME:    setting.debounce = value[DEBOUNCE_BITS-1:0];
            CSR_DOWN_IS_POSITIVE: setting.down_pos = value[0];
            default: ;
         endcase
      endfunction

      // Advance the detector state for one accepted request and queue its direction.
      function void note_request(sample_type s);
         logic [15:0] ax, ay, an;
         logic [63:0] mag_sq, lo, hi;
         logic [1:0]  dir;
         requests++;
         dir = DIR_NONE;
         ax  = s.x[15] ? 16'(-s.x) : 16'(s.x);
         ay  = s.y[15] ? 16'(-s.y) : 16'(s.y);
         an  = s.z[15] ? 16'(-s.z) : 16'(s.z);
         if (s.func) begin
            armed     = 1'b1;
            hits      = '0;
            last_fire = '0;
         end else if (!setting.enable) begin
            dir = DIR_NONE;
         end else if (!armed) begin
            if (an < setting.neutral) armed = 1'b1;
         end else begin
            mag_sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(an) * 64'(an);
            lo     = 64'(ONE_G) - 64'(setting.band);
            hi     = 64'(ONE_G) + 64'(setting.band);
            if (!(mag_sq > lo * lo && mag_sq < hi * hi) || an < 16'(setting.trigger)) begin
               hits = '0;
            end else begin
               if (hits != 4'hF) hits++;
               if (hits >= setting.confirm) begin
                  hits = '0;
                  // a timestamp behind the last fire never meets the debounce
                  if (s.t >= last_fire && s.t - last_fire >= 48'(setting.debounce)) begin
                     last_fire = s.t;
                     armed     = 1'b0;
                     dir = ((s.z > 0) == setting.down_pos) ? DIR_DOWN : DIR_UP;
                  end
               end
            end
         end
         expected_dirs.push_back(dir);
      endfunction

      function void check_response(logic [1:0] dir);
         logic [1:0] want;
         responses++;
         if (expected_dirs.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected nothing, actual direction %0d",
                     $time, dir);
            return;
         end
         want = expected_dirs.pop_front();
         if (want == DIR_DOWN) downs++;
         else if (want == DIR_UP) ups++;
         if (dir !== want) begin
            errors++;
            $display("%0t: direction mismatch, expected %0d, actual %0d", $time, want, dir);
         end
      endfunction

      function int pending();
         return expected_dirs.size();
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_func = 1'b0;
   logic signed [ACCEL_BITS-1:0] req_accel_x = '0;
   logic signed [ACCEL_BITS-1:0] req_accel_y = '0;
   logic signed [ACCEL_BITS-1:0] req_accel_z = '0;
   logic [TIME_BITS-1:0]         req_time_us = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [1:0]                   rsp_direction;
   logic                         csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [CSR_DATA_BITS-1:0]     csr_wdata = '0;

   tilt_scoreboard sb;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             hold_token = 0;
   int             hold_seen = 0;
   int             hold_left = 0;
   int             idle_cycles = 0;
   int             settings_written = 0;
   logic [47:0]    now_us = '0;

   tilt_gesture_detector uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_accel_x(req_accel_x), .req_accel_y(req_accel_y), .req_accel_z(req_accel_z),
      .req_time_us(req_time_us),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_direction(rsp_direction),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: a requested long hold first, otherwise random stalls.
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_direction);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Offer one request, starting and ending at a falling edge.
   task automatic send_sample(input logic func, input int x, input int y, input int z,
                              input logic [47:0] t);
      sample_type s;
      s.func = func;
      s.x    = ACCEL_BITS'(x);
      s.y    = ACCEL_BITS'(y);
      s.z    = ACCEL_BITS'(z);
      s.t    = t;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= s.func;
      req_accel_x <= s.x;
      req_accel_y <= s.y;
      req_accel_z <= s.z;
      req_time_us <= s.t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(s);
      @(negedge clock);
   endtask

   // Drop valid and wait until every queued direction has come back.
   task automatic drain_all();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_BITS-1:0] index,
                          input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_setting(index, data);
      @(negedge clock);
   endtask

   task automatic write_settings(input tilt_settings_type s);
      put_reg(CSR_DETECT_ENABLE, 24'(s.enable));
      put_reg(CSR_NEUTRAL_LEVEL, 24'(s.neutral));
      put_reg(CSR_TRIGGER_LEVEL, 24'(s.trigger));
      put_reg(CSR_STEADY_BAND, 24'(s.band));
      put_reg(CSR_CONFIRM_COUNT, 24'(s.confirm));
      put_reg(CSR_DEBOUNCE_TIME, 24'(s.debounce));
      put_reg(CSR_DOWN_IS_POSITIVE, 24'(s.down_pos));
      csr_we <= 1'b0;
      settings_written++;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct <= sender_pct;
      recv_idle_pct <= receiver_pct;
      @(negedge clock);
   endtask

   function automatic tilt_settings_type random_settings();
      tilt_settings_type s;
      s.enable   = 1'b1;
      s.neutral  = LEVEL_BITS'($urandom_range(800, 2600));
      s.trigger  = LEVEL_BITS'($urandom_range(1800, 3800));
      s.band     = BAND_BITS'($urandom_range(1200, 3200));
      s.confirm  = COUNT_BITS'($urandom_range(0, 4));
      s.debounce = DEBOUNCE_BITS'($urandom_range(0, 500000));
      s.down_pos = 1'($urandom_range(0, 1));
      return s;
   endfunction

   task automatic run_directed();
      tilt_settings_type cfg;
      // rearm with every field at an extreme
      send_sample(1'b1, 32767, -32768, -1, 48'hFFFF_FFFF_FFFF);
      // two hits too early after time zero: debounce not met, stays armed
      send_sample(1'b0, 0, 0, 4096, 48'd1000);
      send_sample(1'b0, 0, 0, 4096, 48'd2000);
      send_sample(1'b0, 0, 0, 4000, 48'd800000);
      send_sample(1'b0, 100, -100, 4000, 48'd800100);
      // disarmed: stays disarmed until the normal axis drops below neutral
      send_sample(1'b0, 0, 0, 4000, 48'd900000);
      send_sample(1'b0, 0, 0, 1637, 48'd900100);
      send_sample(1'b0, 0, 0, -4096, 48'd1600000);
      send_sample(1'b0, 0, 0, -4096, 48'd1600200);
      send_sample(1'b0, 4096, 0, 0, 48'd1700000);
      send_sample(1'b0, -32768, -32768, -32768, 48'd1800000);
      send_sample(1'b0, 32767, 32767, 32767, 48'd1800001);
      send_sample(1'b0, 0, 0, -32768, 48'd1800002);
      // timestamps behind the last fire
      send_sample(1'b0, 0, 0, 4096, 48'd5);
      send_sample(1'b0, 0, 0, 4096, 48'd6);
      // rearm clears the last fire; fire exactly at the debounce boundary
      send_sample(1'b1, 0, 0, 0, 48'd0);
      send_sample(1'b0, 0, 0, 4096, 48'd699999);
      send_sample(1'b0, 0, 0, 4096, 48'd700000);
      send_sample(1'b0, 0, 0, 0, 48'd700001);
      send_sample(1'b0, 0, 0, 4096, 48'hFFFF_FFFF_FFFE);
      send_sample(1'b0, 0, 0, 4096, 48'hFFFF_FFFF_FFFF);
      drain_all();
      // zero confirm count and zero trigger: a flat sample fires, n = 0 is not positive
      cfg         = RESET_SETTINGS;
      cfg.confirm = '0;
      cfg.trigger = '0;
      write_settings(cfg);
      send_sample(1'b1, 0, 0, 0, 48'd0);
      send_sample(1'b0, 4096, 0, 0, 48'd9000000);
      drain_all();
      // detection off: samples report none, rearm still clears state
      cfg.enable = 1'b0;
      write_settings(cfg);
      send_sample(1'b0, 0, 0, 4096, 48'd9500000);
      send_sample(1'b1, -1, -1, -1, 48'd0);
      drain_all();
      // pending hits past a lowered confirm count fire on the next hit
      cfg         = RESET_SETTINGS;
      cfg.confirm = 4'hF;
      write_settings(cfg);
      repeat (5) begin
         now_us = now_us + 48'd1000;
         send_sample(1'b0, 0, 0, 4096, 48'd10000000 + now_us);
      end
      drain_all();
      cfg.confirm = 4'd3;
      write_settings(cfg);
      send_sample(1'b0, 0, 0, 4096, 48'd10100000);
      drain_all();
   endtask

   // Mostly tilt gestures and returns to neutral, with noise, rearms and time jumps.
   task automatic run_random(input int count);
      int   sent;
      int   kind;
      int   burst;
      int   mag;
      logic neg;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            burst = $urandom_range(1, 6);
            neg   = $urandom_range(0, 1);
            repeat (burst) begin
               mag    = $urandom_range(2300, 5600);
               now_us = now_us + 48'($urandom_range(2000, 260000));
               send_sample(1'b0, $urandom_range(0, 3000) - 1500,
                           $urandom_range(0, 3000) - 1500, neg ? -mag : mag, now_us);
               sent++;
            end
         end else if (kind < 78) begin
            burst = $urandom_range(1, 3);
            repeat (burst) begin
               now_us = now_us + 48'($urandom_range(2000, 260000));
               mag    = $urandom_range(2500, 4000);
               send_sample(1'b0, $urandom_range(0, 1) ? -mag : mag,
                           $urandom_range(0, 1000) - 500, $urandom_range(0, 2400) - 1200,
                           now_us);
               sent++;
            end
         end else if (kind < 90) begin
            send_sample(1'b0, $urandom(), $urandom(), $urandom(),
                        48'({$urandom(), $urandom()}));
            sent++;
         end else if (kind < 95) begin
            send_sample(1'b1, $urandom(), $urandom(), $urandom(),
                        48'({$urandom(), $urandom()}));
            sent++;
         end else if ($urandom_range(0, 1)) begin
            now_us = 48'({$urandom(), $urandom()});
         end else begin
            now_us = now_us - 48'($urandom_range(0, 500000));
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      // receiver mostly stalled; open with a long hold so the input backs up
      set_idling(16, 81);
      write_settings(random_settings());
      hold_token <= hold_token + 1;
      run_random(90);
      drain_all();
      write_settings(FIRE_SETTINGS);
      run_random(40);
      drain_all();

      // sender mostly idle; pause halfway until everything is back
      set_idling(81, 16);
      write_settings(random_settings());
      run_random(60);
      drain_all();
      run_random(40);
      drain_all();
      write_settings(QUIET_SETTINGS);
      run_random(20);
      drain_all();

      // full rate both ways
      set_idling(0, 0);
      write_settings(RESET_SETTINGS);
      run_random(80);
      drain_all();
      write_settings(random_settings());
      run_random(70);
      drain_all();

      $display("Run covered %0d requests and %0d responses (%0d down, %0d up)",
               sb.requests, sb.responses, sb.downs, sb.ups);
      $display("over %0d register settings and three idling mixes", settings_written);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
